>>> hw/rtl/maze_carver_backtracker_top_defines.svh
// Assertion macros for the checker file.
`ifndef MAZE_CARVER_BACKTRACKER_TOP_DEFINES_SVH
`define MAZE_CARVER_BACKTRACKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MCB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mcb_pkg.sv
`default_nettype none

package mcb_pkg;

    localparam int MAX_COLS_DEF    = 64;
    localparam int MAX_ROWS_DEF    = 32;
    localparam int STACK_DEPTH_DEF = 512;

    localparam logic [6:0] WIDTH_RESET  = 7'd50;
    localparam logic [5:0] HEIGHT_RESET = 6'd30;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_SHUFFLE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] swap_pick_three;
        logic [1:0] swap_pick_two;
        logic       swap_pick_one;
        logic [5:0] query_col;
        logic [4:0] query_row;
    } t_in_item;

    typedef struct packed {
        logic [5:0] cell_col;
        logic [4:0] cell_row;
        logic       cell_open;
        logic       maze_done;
        logic       last_of_run;
    } t_out_item;

    function automatic logic [3:0][1:0] shuffle_order(
        input logic [1:0] p3,
        input logic [1:0] p2,
        input logic       p1
    );
        logic [3:0][1:0] o;
        logic [1:0]      q2;
        logic [1:0]      q1;
        logic [1:0]      t;
        o     = {2'd3, 2'd2, 2'd1, 2'd0};
        q2    = (p2 > 2'd2) ? 2'd2 : p2;
        q1    = {1'b0, p1};
        t     = o[3];
        o[3]  = o[p3];
        o[p3] = t;
        t     = o[2];
        o[2]  = o[q2];
        o[q2] = t;
        t     = o[1];
        o[1]  = o[q1];
        o[q1] = t;
        return o;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mcb_ram.sv
`default_nettype none

module mcb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/maze_carver_backtracker_top.sv
// Maze carver. Input items arrive on i_in_valid / o_in_stall with payload i_in_item,
// results leave on o_out_valid / i_out_stall with payload o_out_item.
// The grid size in use is set through i_cfg_we, i_cfg_index and i_cfg_data, by the user
// only while idle; the block does not enforce this. After reset the cell map is swept
// clear, one cell a cycle, all 2**(log2 cols + log2 rows) cells (2048 at the default
// size); a start item runs the same sweep. A query reads the map as it is accepted; S_QRD
// registers its result. A shuffle item pushes its frame as it is accepted, then in S_WALK
// skips a direction off the grid, reads the map in S_MAPRD for one on it, pops a spent
// frame via S_LOAD and opens a passage via S_OPENM and S_OPENN; the map and the frame
// stack have one read port each. An opening gives two items, the end of carving one.
// The block accepts one item at a time and holds o_in_stall high until every result of
// that item has been taken. A stalled result holds on the output register.
`default_nettype none

module maze_carver_backtracker_top #(
    parameter int MAX_COLS    = mcb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = mcb_pkg::MAX_ROWS_DEF,
    parameter int STACK_DEPTH = mcb_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire mcb_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output mcb_pkg::t_out_item     o_out_item,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [6:0]        i_cfg_data
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int AW  = CW + RW;
    localparam int MD  = 1 << AW;
    localparam int CM  = (CW > RW) ? CW : RW;
    localparam int CRW = (CM > 7) ? CM : 7;
    localparam int PW  = CRW + 2;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic [CW-1:0]   col;
        logic [RW-1:0]   row;
        logic [3:0][1:0] order;
        logic [2:0]      nxt;
    } t_frame;

    localparam int FW = $bits(t_frame);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_MAPRD = 4'd4;
    localparam logic [3:0] S_OPENM = 4'd5;
    localparam logic [3:0] S_OPENN = 4'd6;
    localparam logic [3:0] S_QRD   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]         r_state;
    logic [AW-1:0]      r_clr;
    logic [DW-1:0]      r_depth;
    logic [CW-1:0]      r_cur_col;
    logic [RW-1:0]      r_cur_row;
    logic               r_active;
    t_frame             r_top;
    logic [PW-1:0]      r_mc;
    logic [PW-1:0]      r_mr;
    logic [PW-1:0]      r_nc;
    logic [PW-1:0]      r_nr;
    logic               r_qin;
    logic [5:0]         r_qcol;
    logic [4:0]         r_qrow;
    logic               r_out_valid;
    mcb_pkg::t_out_item r_out;
    mcb_pkg::t_out_item r_pend;
    logic               r_more;
    logic [6:0]         r_width;
    logic [5:0]         r_height;

    logic [PW-1:0] w_cols;
    logic [PW-1:0] w_rows;
    logic [PW-1:0] w_tc;
    logic [PW-1:0] w_tr;
    logic [PW-1:0] w_mc;
    logic [PW-1:0] w_mr;
    logic [PW-1:0] w_nc;
    logic [PW-1:0] w_nr;
    logic          w_edge_ok;
    logic          w_walk_ok;
    logic [1:0]    w_dir;
    logic [PW-1:0] w_qc;
    logic [PW-1:0] w_qr;
    logic          w_q_ok;
    t_frame        w_new;
    logic          w_accept;
    logic [DW-1:0] w_dm1;
    logic [DW-1:0] w_dm2;

    logic          map_we;
    logic [AW-1:0] map_waddr;
    logic          map_wdata;
    logic [AW-1:0] map_raddr;
    logic          map_rdata;
    logic          st_we;
    logic [SAW-1:0] st_waddr;
    logic [FW-1:0] st_wdata;
    logic [SAW-1:0] st_raddr;
    logic [FW-1:0] st_rdata;

    function automatic logic [AW-1:0] map_addr(input logic [PW-1:0] c, input logic [PW-1:0] r);
        return {r[RW-1:0], c[CW-1:0]};
    endfunction

    always_comb begin
        w_cols = PW'(r_width);
        if (w_cols == '0) begin
            w_cols = PW'(1);
        end else if (w_cols > PW'(MAX_COLS)) begin
            w_cols = PW'(MAX_COLS);
        end
        w_rows = PW'(r_height);
        if (w_rows == '0) begin
            w_rows = PW'(1);
        end else if (w_rows > PW'(MAX_ROWS)) begin
            w_rows = PW'(MAX_ROWS);
        end
    end

    always_comb begin
        w_dir = r_top.order[r_top.nxt[1:0]];
        w_tc  = PW'(r_top.col);
        w_tr  = PW'(r_top.row);
        w_mc  = w_tc;
        w_nc  = w_tc;
        w_mr  = w_tr;
        w_nr  = w_tr;
        w_edge_ok = 1'b1;
        unique case (w_dir)
            mcb_pkg::DIR_NORTH: begin
                w_mr = w_tr - PW'(1);
                w_nr = w_tr - PW'(2);
                w_edge_ok = (w_tr >= PW'(2));
            end
            mcb_pkg::DIR_EAST: begin
                w_mc = w_tc + PW'(1);
                w_nc = w_tc + PW'(2);
            end
            mcb_pkg::DIR_SOUTH: begin
                w_mr = w_tr + PW'(1);
                w_nr = w_tr + PW'(2);
            end
            mcb_pkg::DIR_WEST: begin
                w_mc = w_tc - PW'(1);
                w_nc = w_tc - PW'(2);
                w_edge_ok = (w_tc >= PW'(2));
            end
            default: begin
                w_edge_ok = 1'b0;
            end
        endcase
        w_walk_ok = w_edge_ok && (w_nc < w_cols) && (w_nr < w_rows);
    end

    assign w_qc   = PW'(i_in_item.query_col);
    assign w_qr   = PW'(i_in_item.query_row);
    assign w_q_ok = (w_qc < w_cols) && (w_qr < w_rows);

    always_comb begin
        w_new.col   = r_cur_col;
        w_new.row   = r_cur_row;
        w_new.order = mcb_pkg::shuffle_order(i_in_item.swap_pick_three,
                                             i_in_item.swap_pick_two,
                                             i_in_item.swap_pick_one);
        w_new.nxt   = 3'd0;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_dm1      = r_depth - DW'(1);
    assign w_dm2      = r_depth - DW'(2);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = 1'b0;
        map_raddr = '0;
        st_we     = 1'b0;
        st_waddr  = r_depth[SAW-1:0];
        st_wdata  = w_new;
        st_raddr  = w_dm2[SAW-1:0];
        unique case (r_state)
            S_CLR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
            end
            S_IDLE: begin
                map_raddr = map_addr(w_qc, w_qr);
                if (w_accept && i_in_item.opcode == mcb_pkg::OP_SHUFFLE && r_active) begin
                    map_we    = 1'b1;
                    map_waddr = {r_cur_row, r_cur_col};
                    map_wdata = 1'b1;
                    st_we     = (r_depth < DW'(STACK_DEPTH));
                end
            end
            S_WALK: begin
                map_raddr = map_addr(w_nc, w_nr);
            end
            S_OPENM: begin
                map_we    = 1'b1;
                map_waddr = map_addr(r_mc, r_mr);
                map_wdata = 1'b1;
            end
            S_OPENN: begin
                map_we    = 1'b1;
                map_waddr = map_addr(r_nc, r_nr);
                map_wdata = 1'b1;
                st_we     = 1'b1;
                st_waddr  = w_dm1[SAW-1:0];
                st_wdata  = r_top;
            end
            S_LOAD, S_MAPRD, S_QRD, S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_depth     <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_more      <= 1'b0;
            r_width     <= mcb_pkg::WIDTH_RESET;
            r_height    <= mcb_pkg::HEIGHT_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mcb_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    mcb_pkg::CFG_HEIGHT: r_height <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_in_item.opcode)
                            mcb_pkg::OP_START: begin
                                r_depth   <= '0;
                                r_cur_col <= '0;
                                r_cur_row <= '0;
                                r_active  <= 1'b1;
                                r_clr     <= '0;
                                r_state   <= S_CLR;
                            end
                            mcb_pkg::OP_SHUFFLE: begin
                                if (r_active) begin
                                    if (r_depth < DW'(STACK_DEPTH)) begin
                                        r_depth <= r_depth + DW'(1);
                                        r_top   <= w_new;
                                    end
                                    r_state <= S_WALK;
                                end
                            end
                            mcb_pkg::OP_QUERY: begin
                                r_qin   <= w_q_ok;
                                r_qcol  <= i_in_item.query_col;
                                r_qrow  <= i_in_item.query_row;
                                r_state <= S_QRD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_depth == '0) begin
                        r_active    <= 1'b0;
                        r_out       <= '{cell_col: 6'd0, cell_row: 5'd0, cell_open: 1'b0,
                                         maze_done: 1'b1, last_of_run: 1'b1};
                        r_more      <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (r_top.nxt[2]) begin
                        r_depth <= w_dm1;
                        if (w_dm1 != '0) begin
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_top.nxt <= r_top.nxt + 3'd1;
                        r_mc <= w_mc;
                        r_mr <= w_mr;
                        r_nc <= w_nc;
                        r_nr <= w_nr;
                        if (w_walk_ok) begin
                            r_state <= S_MAPRD;
                        end
                    end
                end
                S_LOAD: begin
                    r_top   <= st_rdata;
                    r_state <= S_WALK;
                end
                S_MAPRD: begin
                    r_state <= map_rdata ? S_WALK : S_OPENM;
                end
                S_OPENM: begin
                    r_state <= S_OPENN;
                end
                S_OPENN: begin
                    r_cur_col   <= r_nc[CW-1:0];
                    r_cur_row   <= r_nr[RW-1:0];
                    r_out       <= '{cell_col: r_mc[5:0], cell_row: r_mr[4:0], cell_open: 1'b1,
                                     maze_done: 1'b0, last_of_run: 1'b0};
                    r_pend      <= '{cell_col: r_nc[5:0], cell_row: r_nr[4:0], cell_open: 1'b1,
                                     maze_done: 1'b0, last_of_run: 1'b1};
                    r_more      <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_QRD: begin
                    r_out       <= '{cell_col: r_qcol, cell_row: r_qrow,
                                     cell_open: r_qin & map_rdata,
                                     maze_done: 1'b0, last_of_run: 1'b1};
                    r_more      <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        if (r_more) begin
                            r_out  <= r_pend;
                            r_more <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mcb_ram #(
        .WIDTH(1),
        .DEPTH(MD)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(map_waddr),
        .i_wdata(map_wdata),
        .i_raddr(map_raddr),
        .o_rdata(map_rdata)
    );

    mcb_ram #(
        .WIDTH(FW),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/mcb_checker.sv
`default_nettype none
`include "maze_carver_backtracker_top_defines.svh"

module mcb_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire mcb_pkg::t_out_item o_out_item
);

    `MCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item), "stalled result changed")

    `MCB_ASSERT_SAME(a_done_shape, i_clk, i_rst_n, o_out_valid && o_out_item.maze_done,
        o_out_item.last_of_run && !o_out_item.cell_open &&
        o_out_item.cell_col == 6'd0 && o_out_item.cell_row == 5'd0,
        "done result has wrong fields")

    `MCB_ASSERT_SAME(a_first_open, i_clk, i_rst_n, o_out_valid && !o_out_item.last_of_run,
        o_out_item.cell_open && !o_out_item.maze_done, "first of two results is not an opening")

    `MCB_ASSERT_SAME(a_busy_out, i_clk, i_rst_n, o_out_valid, o_in_stall,
        "item accepted while a result is pending")

    `MCB_ASSERT_NEXT(a_accept_gap, i_clk, i_rst_n, i_in_valid && !o_in_stall, !o_out_valid,
        "result in the cycle after acceptance")

endmodule

bind maze_carver_backtracker_top mcb_checker u_mcb_checker (.*);

`default_nettype wire
